/* src/ckb_pkg.sv */
// ----------------------------------------------------------------------------
// ckb_pkg
// Shared types and constants of the color keyed clipped blit core.
// ----------------------------------------------------------------------------
`default_nettype none

package ckb_pkg;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// item field widths
	localparam int PIX_W  = 16;
	localparam int CNT_W  = 11;
	localparam int ADDR_W = 18;
	localparam int POS_W  = 13;

	// entries of the queue between front and back
	localparam int QDEPTH = 4;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_WIDTH  = 3'd0,
		REG_DEST_X      = 3'd1,
		REG_DEST_Y      = 3'd2,
		REG_COLOR_KEY   = 3'd3,
		REG_CLIP_LEFT   = 3'd4,
		REG_CLIP_TOP    = 3'd5,
		REG_CLIP_RIGHT  = 3'd6,
		REG_CLIP_BOTTOM = 3'd7
	} reg_idx_t;

	// register file contents
	typedef struct packed {
		logic        [10:0] dest_width;
		logic signed [11:0] dest_x;
		logic signed [11:0] dest_y;
		logic signed [16:0] color_key;
		logic signed [11:0] clip_left;
		logic signed [11:0] clip_top;
		logic signed [11:0] clip_right;
		logic signed [11:0] clip_bottom;
	} cfg_t;

	// one visible pixel waiting for its address
	typedef struct packed {
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		logic [PIX_W-1:0] pixel;
	} q_entry_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

`default_nettype wire

/* src/ckb_ifs.sv */
// ----------------------------------------------------------------------------
// ckb_ifs
// Valid/ready channels of the blit core: pixel in, write out, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ckb_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel;
	logic        end_of_row;
	logic        end_of_image;
	modport source (output valid, pixel, end_of_row, end_of_image, input ready);
	modport sink   (input valid, pixel, end_of_row, end_of_image, output ready);
endinterface

interface ckb_wr_if;
	logic        valid;
	logic        ready;
	logic [17:0] write_address;
	logic [15:0] write_data;
	modport source (output valid, write_address, write_data, input ready);
	modport sink   (input valid, write_address, write_data, output ready);
endinterface

interface ckb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/ckb_queue.sv */
// ----------------------------------------------------------------------------
// ckb_queue
// Short register queue between the pixel front and the address back.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ckb_pkg::q_entry_t push_data,
	input  wire logic             pop,
	output ckb_pkg::q_entry_t     head,
	output ckb_pkg::q_stat_t      stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ckb_pkg::q_entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head          = mem_q[rd_ptr_q];
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.nonempty = (count_q != '0);

endmodule

`default_nettype wire

/* src/ckb_front.sv */
// ----------------------------------------------------------------------------
// ckb_front
// Source counters, destination position, clip and color key test.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_front #(
	parameter int DEST_ROWS = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ckb_pkg::cfg_t cfg,
	input  wire ckb_pkg::q_stat_t qstat,
	ckb_pix_if.sink            pix,
	output logic               push,
	output ckb_pkg::q_entry_t  push_data
);

	localparam logic signed [ckb_pkg::POS_W-1:0] ROWS_S = ckb_pkg::POS_W'(DEST_ROWS);

	logic [ckb_pkg::CNT_W-1:0] col_q;
	logic [ckb_pkg::CNT_W-1:0] row_q;

	logic                             accept;
	logic signed [ckb_pkg::POS_W-1:0] tx, ty;
	logic signed [ckb_pkg::POS_W-1:0] cx0, cy0, cx1, cy1;
	logic signed [ckb_pkg::POS_W-1:0] cr, cb, dw;
	logic                             visible;
	logic                             key_hit;

	assign pix.ready = !qstat.full;
	assign accept    = pix.valid && pix.ready;

	// destination position
	always_comb begin
		tx = $signed({cfg.dest_x[11], cfg.dest_x}) + $signed({2'b00, col_q});
		ty = $signed({cfg.dest_y[11], cfg.dest_y}) + $signed({2'b00, row_q});
	end

	// effective clip rectangle
	always_comb begin
		cx0 = cfg.clip_left[11] ? '0 : $signed({1'b0, cfg.clip_left});
		cy0 = cfg.clip_top[11]  ? '0 : $signed({1'b0, cfg.clip_top});
		cr  = $signed({cfg.clip_right[11], cfg.clip_right});
		cb  = $signed({cfg.clip_bottom[11], cfg.clip_bottom});
		dw  = $signed({2'b00, cfg.dest_width});
		cx1 = (cr > dw) ? dw : cr;
		cy1 = (cb > ROWS_S) ? ROWS_S : cb;
	end

	// visibility and transparent key
	assign visible = (tx >= cx0) && (tx < cx1) && (ty >= cy0) && (ty < cy1);
	assign key_hit = !cfg.color_key[16] && (pix.pixel == cfg.color_key[15:0]);

	assign push            = accept && visible && !key_hit;
	assign push_data.row   = ty[ckb_pkg::CNT_W-1:0];
	assign push_data.col   = tx[ckb_pkg::CNT_W-1:0];
	assign push_data.pixel = pix.pixel;

	// source column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			priority if (pix.end_of_image) begin
				col_q <= '0;
				row_q <= '0;
			end else if (pix.end_of_row) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/ckb_back.sv */
// ----------------------------------------------------------------------------
// ckb_back
// Linear address of each queued pixel: multiply stage, then add and output.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ckb_pkg::cfg_t cfg,
	input  wire ckb_pkg::q_stat_t qstat,
	input  wire ckb_pkg::q_entry_t head,
	output logic               pop,
	ckb_wr_if.source           wr
);

	localparam int PROD_W = 2 * ckb_pkg::CNT_W;

	logic                      v_s1;
	logic [PROD_W-1:0]         prod_s1;
	logic [ckb_pkg::CNT_W-1:0] col_s1;
	logic [ckb_pkg::PIX_W-1:0] pixel_s1;

	logic                      v_s2;
	logic [ckb_pkg::ADDR_W-1:0] addr_s2;
	logic [ckb_pkg::PIX_W-1:0] data_s2;

	logic adv1, adv2;
	logic [PROD_W-1:0] sum;

	// stage advance under output stall
	assign adv2 = !v_s2 || wr.ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = qstat.nonempty && adv1;

	assign sum = prod_s1 + PROD_W'(col_s1);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= qstat.nonempty;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// row times width, then column added
	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1  <= head.row * cfg.dest_width;
			col_s1   <= head.col;
			pixel_s1 <= head.pixel;
		end
		if (adv2 && v_s1) begin
			addr_s2 <= sum[ckb_pkg::ADDR_W-1:0];
			data_s2 <= pixel_s1;
		end
	end

	assign wr.valid         = v_s2;
	assign wr.write_address = addr_s2;
	assign wr.write_data    = data_s2;

endmodule

`default_nettype wire

/* src/color_keyed_clipped_blit_core.sv */
// ----------------------------------------------------------------------------
// color_keyed_clipped_blit_core
// Clipped, color keyed blit of an RGB565 stream into linear framebuffer writes.
//
//   channel | dir | payload                          | handshake
//   pix     | in  | pixel, end_of_row, end_of_image  | valid/ready
//   wr      | out | write_address, write_data        | valid/ready
//   cfg     | in  | index, data                      | valid/ready (ready high)
//
// One pixel request per cycle while the queue is not full; the front classifies it
// in the accept cycle. A visible pixel passes the queue, the multiply stage and the
// add stage to the write port; the multiplier paces the back at one per cycle when
// writes are not stalled. A 4 entry queue lets the front keep taking pixels while
// writes are stalled; pixel ready drops only when it is full. Reset restores register
// defaults and clears the source counters and all valid state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module color_keyed_clipped_blit_core #(
	parameter int DEST_ROWS = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ckb_pix_if.sink   pix,
	ckb_wr_if.source  wr,
	ckb_cfg_if.sink   cfg
);

	ckb_pkg::cfg_t     cfg_q;
	ckb_pkg::q_stat_t  qstat;
	ckb_pkg::q_entry_t push_data;
	ckb_pkg::q_entry_t head;
	logic              push;
	logic              pop;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_width  <= 11'd320;
			cfg_q.dest_x      <= '0;
			cfg_q.dest_y      <= '0;
			cfg_q.color_key   <= '1;
			cfg_q.clip_left   <= '0;
			cfg_q.clip_top    <= '0;
			cfg_q.clip_right  <= 12'sd320;
			cfg_q.clip_bottom <= 12'sd240;
		end else if (cfg.valid && cfg.ready) begin
			unique case (ckb_pkg::reg_idx_t'(cfg.index))
				ckb_pkg::REG_DEST_WIDTH:  cfg_q.dest_width  <= cfg.data[10:0];
				ckb_pkg::REG_DEST_X:      cfg_q.dest_x      <= cfg.data[11:0];
				ckb_pkg::REG_DEST_Y:      cfg_q.dest_y      <= cfg.data[11:0];
				ckb_pkg::REG_COLOR_KEY:   cfg_q.color_key   <= cfg.data;
				ckb_pkg::REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg.data[11:0];
				ckb_pkg::REG_CLIP_TOP:    cfg_q.clip_top    <= cfg.data[11:0];
				ckb_pkg::REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg.data[11:0];
				ckb_pkg::REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// classify pixels
	ckb_front #(
		.DEST_ROWS (DEST_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.pix       (pix),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	ckb_queue #(
		.DEPTH (ckb_pkg::QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	// address generation and write port
	ckb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.wr     (wr)
	);

endmodule

`default_nettype wire

/* src/ckb_checker.sv */
// ----------------------------------------------------------------------------
// ckb_checker
// Port level checks of the blit core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [17:0] out_address,
	input wire logic [15:0] out_data,
	input wire logic        cfg_ready
);

	// a stalled write request stays up
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("write request dropped while stalled");

	// a stalled write request keeps its payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_address) && $stable(out_data))
		else $error("write payload changed while stalled");

	// configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

	// queue can only fill through an accepted pixel
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("pixel ready fell without an accepted request");

endmodule

bind color_keyed_clipped_blit_core ckb_checker u_ckb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pix.valid),
	.in_ready    (pix.ready),
	.out_valid   (wr.valid),
	.out_ready   (wr.ready),
	.out_address (wr.write_address),
	.out_data    (wr.write_data),
	.cfg_ready   (cfg.ready)
);

`default_nettype wire
